### hw/rtl/rotated_sorted_table_search_top_macros.svh
// Assertion macros for the rotated sorted table search block
`ifndef ROTATED_SORTED_TABLE_SEARCH_TOP_MACROS_SVH
`define ROTATED_SORTED_TABLE_SEARCH_TOP_MACROS_SVH

// same-cycle implication
`define RSTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rsts_pkg.sv
// Shared types and constants of the rotated sorted table search block
`default_nettype none

package rsts_pkg;

   localparam int FIELD_WIDTH         = 32;
   localparam int INDEX_WIDTH         = 10;
   localparam int LENGTH_WIDTH        = 11;
   localparam int DEPTH_DEFAULT       = 1024;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [INDEX_WIDTH-1:0] index;
      logic [FIELD_WIDTH-1:0] value;
      logic [FIELD_WIDTH-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] position;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/rsts_ifs.sv
// Channel interfaces: request, response and length register write
`default_nettype none

interface rsts_req_if import rsts_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [INDEX_WIDTH-1:0] entry_index;
   logic [FIELD_WIDTH-1:0] entry_value;
   logic [FIELD_WIDTH-1:0] search_key;

   modport source (output valid, action, entry_index, entry_value, search_key, input ready);
   modport sink   (input valid, action, entry_index, entry_value, search_key, output ready);
endinterface

interface rsts_rsp_if import rsts_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [INDEX_WIDTH-1:0] position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

interface rsts_csr_if import rsts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [LENGTH_WIDTH-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rsts_engine.sv
// Table memory and probe sequencer with one shared comparator
`default_nettype none

module rsts_engine import rsts_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  cmd_type                 cmd,
   output logic                    ready,
   input  logic [LENGTH_WIDTH-1:0] length,
   input  logic                    room,
   output logic                    done,
   output result_type              result
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 2;
   localparam int LW = (LENGTH_WIDTH > CW) ? LENGTH_WIDTH : CW;
   localparam int IW = (INDEX_WIDTH > AW + 1) ? INDEX_WIDTH : AW + 1;
   localparam logic signed [CW-1:0] ONE = CW'(1);
   localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ISSUE = 6'b000010,
      ST_MID   = 6'b000100,
      ST_LO    = 6'b001000,
      ST_LAST  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic signed [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in, vm_ff, vm_in, vl_ff, vl_in;
   logic kle_ff, kle_in;   // key <= mid entry
   logic mle_ff, mle_in;   // mid entry <= key
   logic left_ff, left_in; // lower half sorted
   logic found_ff, found_in;
   logic [INDEX_WIDTH-1:0] pos_ff, pos_in;

   logic [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic signed [VALUE_WIDTH-1:0] mem_q_ff;
   logic [AW-1:0] mem_addr;
   logic mem_we;

   logic signed [VALUE_WIDTH-1:0] cmp_a, cmp_b;
   logic cmp_lt, cmp_eq, cmp_le;

   logic signed [CW-1:0] span, mid, hi_start;
   logic [LW-1:0] len_ext, len_clamp;
   logic in_range, go_left;
   logic signed [VALUE_WIDTH-1:0] wr_val, key_val;

   assign len_ext   = LW'(length);
   assign len_clamp = (len_ext > DEPTH_L) ? DEPTH_L : len_ext;
   assign hi_start  = $signed(CW'(len_clamp)) - ONE;
   assign span      = hi_ff - lo_ff;
   assign mid       = lo_ff + (span >>> 1);
   assign in_range  = IW'(cmd.index) < IW'(DEPTH);
   assign wr_val    = VALUE_WIDTH'($signed(cmd.value));
   assign key_val   = VALUE_WIDTH'($signed(cmd.key));

   // shared comparator, operands chosen by the sequencer
   always_comb begin
      cmp_a = key_ff;
      cmp_b = mem_q_ff;
      case (state_ff)
         ST_LO: begin
            cmp_a = mem_q_ff;
            cmp_b = vm_ff;
         end
         ST_LAST: begin
            cmp_a = left_ff ? vl_ff : key_ff;
            cmp_b = left_ff ? key_ff : mem_q_ff;
         end
         default: begin
            cmp_a = key_ff;
            cmp_b = mem_q_ff;
         end
      endcase
   end

   assign cmp_lt = cmp_a < cmp_b;
   assign cmp_eq = cmp_a == cmp_b;
   assign cmp_le = cmp_lt | cmp_eq;

   assign go_left = left_ff ? (cmp_le && kle_ff) : !(mle_ff && cmp_le);

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      key_in   = key_ff;
      vm_in    = vm_ff;
      vl_in    = vl_ff;
      kle_in   = kle_ff;
      mle_in   = mle_ff;
      left_in  = left_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      mem_addr = mid[AW-1:0];
      mem_we   = 1'b0;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            mem_addr = AW'(cmd.index);
            if (cmd_valid) begin
               if (cmd.action == ACTION_WRITE) begin
                  mem_we = in_range;
               end else begin
                  lo_in    = '0;
                  hi_in    = hi_start;
                  key_in   = key_val;
                  found_in = 1'b0;
                  pos_in   = '0;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            // read of mid goes out here; empty window ends the search
            state_in = (hi_ff < lo_ff) ? ST_DONE : ST_MID;
         end
         ST_MID: begin
            mem_addr = lo_ff[AW-1:0];
            vm_in    = mem_q_ff;
            kle_in   = cmp_le;
            mle_in   = !cmp_lt;
            if (cmp_eq) begin
               found_in = 1'b1;
               pos_in   = INDEX_WIDTH'($unsigned(mid));
               state_in = ST_DONE;
            end else begin
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            mem_addr = hi_ff[AW-1:0];
            vl_in    = mem_q_ff;
            left_in  = cmp_le;
            state_in = ST_LAST;
         end
         ST_LAST: begin
            if (go_left) begin
               hi_in = mid - ONE;
            end else begin
               lo_in = mid + ONE;
            end
            state_in = ST_ISSUE;
         end
         ST_DONE: begin
            done = room;
            if (room) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      key_ff   <= key_in;
      vm_ff    <= vm_in;
      vl_ff    <= vl_in;
      kle_ff   <= kle_in;
      mle_ff   <= mle_in;
      left_ff  <= left_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr] <= wr_val;
      end
      mem_q_ff <= mem_ff[mem_addr];
   end

   assign ready           = state_ff == ST_IDLE;
   assign result.found    = found_ff;
   assign result.position = pos_ff;

endmodule

`default_nettype wire

### hw/rtl/rotated_sorted_table_search_top.sv
// Write transfer: taken while idle; the engine stays ready.
// Search: each probe steps through the ISSUE, MID, LO and LAST states, reading
// mid, low and high through the single table memory port, for at most
// floor(log2(length))+1 probes. One item at a time.
// The result register lets a new item in while a result waits.
// Reset clears the length register to 0 and all control; table is undefined until written.
`default_nettype none

`include "rotated_sorted_table_search_top_macros.svh"

module rotated_sorted_table_search_top import rsts_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rsts_req_if.sink   req_if,
   rsts_rsp_if.source rsp_if,
   rsts_csr_if.sink   csr_if
);

   logic [LENGTH_WIDTH-1:0] length_ff;
   logic rsp_valid_ff;
   logic rsp_found_ff;
   logic [INDEX_WIDTH-1:0] rsp_position_ff;

   cmd_type    cmd;
   result_type eng_result;
   logic eng_ready, eng_done, room, req_xfer;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_if.valid) begin
         length_ff <= csr_if.data;
      end
   end

   assign req_if.ready = eng_ready;
   assign req_xfer     = req_if.valid && eng_ready;
   assign cmd.action   = req_if.action;
   assign cmd.index    = req_if.entry_index;
   assign cmd.value    = req_if.entry_value;
   assign cmd.key      = req_if.search_key;

   assign room = !rsp_valid_ff || rsp_if.ready;

   rsts_engine #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_xfer),
      .cmd       (cmd),
      .ready     (eng_ready),
      .length    (length_ff),
      .room      (room),
      .done      (eng_done),
      .result    (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done) begin
         rsp_found_ff    <= eng_result.found;
         rsp_position_ff <= eng_result.position;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.found    = rsp_found_ff;
   assign rsp_if.position = rsp_position_ff;

   `RSTS_ASSERT_NOW(a_done_has_room, clock, reset, eng_done, room, "finish while result register blocked")
   `RSTS_ASSERT_NEXT(a_rsp_only_from_engine, clock, reset, !rsp_valid_ff && !eng_done, !rsp_valid_ff, "result appeared without a finished search")
   `RSTS_ASSERT_NEXT(a_search_busy, clock, reset, req_xfer && req_if.action == ACTION_SEARCH, !eng_ready, "engine ready right after search transfer")
   `RSTS_ASSERT_NOW(a_miss_pos_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_position_ff == '0, "miss with nonzero position")

endmodule

`default_nettype wire
